// ----- rtl/soa_pkg.sv -----
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants of the strength ownership arbiter
// Operation codes, sizes and the command/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package soa_pkg;
   localparam int NUM_INSTANCES  = 16;
   localparam int MAX_CANDIDATES = 8;
   localparam int WRITER_ID_BITS = 8;
   localparam int SLOT_BITS      = $clog2(NUM_INSTANCES);
   localparam int CAND_BITS      = $clog2(MAX_CANDIDATES);
   localparam int CNT_BITS       = $clog2(MAX_CANDIDATES + 1);
   localparam int WK_DEPTH       = MAX_CANDIDATES + 2;
   localparam int WK_BITS        = $clog2(WK_DEPTH + 1);
   localparam int MEM_DEPTH      = NUM_INSTANCES * MAX_CANDIDATES;
   localparam int MEM_ABITS      = $clog2(MEM_DEPTH);
   localparam int ENTRY_BITS     = WRITER_ID_BITS + 32;

   localparam logic [WRITER_ID_BITS-1:0] NO_WRITER = '0;

   localparam logic [2:0] OP_SAMPLE     = 3'd0;
   localparam logic [2:0] OP_UNREGISTER = 3'd1;
   localparam logic [2:0] OP_REMOVE_ALL = 3'd2;
   localparam logic [2:0] OP_OWNER_LOST = 3'd3;
   localparam logic [2:0] OP_DISPOSE    = 3'd4;
   localparam logic [2:0] OP_QUERY      = 3'd5;

   typedef struct packed {
      logic [2:0]                op;
      logic [SLOT_BITS-1:0]      inst;
      logic [WRITER_ID_BITS-1:0] writer;
      logic signed [31:0]        strength;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]      slot;
      logic [WRITER_ID_BITS-1:0] owner_id;
      logic                      owner_valid;
      logic                      owner_changed;
      logic                      owner_match;
      logic                      dropped;
      logic                      last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic                 take_req;   // latch request
      logic                 set_slot;   // current slot := scan slot
      logic [SLOT_BITS-1:0] scan_slot;
      logic                 load_start; // begin read of list
      logic                 load_step;  // capture one read entry
      logic                 process;    // apply operation to work list
      logic                 sort_step;  // one insertion pass step
      logic                 finish;     // promote / commit slot state
      logic                 store_step; // write one entry back
      logic                 emit;       // build result
      logic                 emit_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic load_done;
      logic sort_done;
      logic store_done;
      logic slot_used;
      logic more_used;   // a used slot lies above the current one
      logic need_list;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/soa_ram.sv -----
// ----------------------------------------------------------------------------
// soa_ram: generic single-port RAM with registered read
// One write or one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module soa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire  [$clog2(DEPTH)-1:0] addr,
   input  wire  [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- rtl/soa_datapath.sv -----
// ----------------------------------------------------------------------------
// soa_datapath: slot state, work list and candidate memory
// Holds per-slot owner state, a small work list of candidates that is loaded,
// edited, insertion sorted one swap a cycle and stored back.
// ----------------------------------------------------------------------------
`default_nettype none
module soa_datapath (
   input  wire               clock,
   input  wire               reset,
   input  wire  soa_pkg::req_type req_in,
   input  wire  soa_pkg::cmd_type cmd,
   output soa_pkg::sts_type  sts,
   output soa_pkg::rsp_type  rsp
);
   import soa_pkg::*;

   logic [NUM_INSTANCES-1:0]  used_ff, used_in;
   logic [NUM_INSTANCES-1:0]  pres_ff, pres_in;
   logic [WRITER_ID_BITS-1:0] ownw_ff [NUM_INSTANCES];
   logic signed [31:0]        owns_ff [NUM_INSTANCES];
   logic [CNT_BITS-1:0]       cnt_ff  [NUM_INSTANCES];

   req_type                   req_ff;
   logic [SLOT_BITS-1:0]      cur_ff;
   logic [WRITER_ID_BITS-1:0] wkw_ff [WK_DEPTH];
   logic signed [31:0]        wks_ff [WK_DEPTH];
   logic [WK_BITS-1:0]        wkn_ff;
   logic [WK_BITS-1:0]        idx_ff;   // load/store index
   logic [WK_BITS-1:0]        si_ff;    // sort outer index
   logic [WK_BITS-1:0]        sj_ff;    // sort inner index
   logic                      chg_ff, drp_ff, promote_ff, commit_ff;

   logic [MEM_ABITS-1:0]  ram_addr;
   logic [ENTRY_BITS-1:0] ram_rdata;
   logic                  ram_we;
   logic [CAND_BITS-1:0]  idx_lo;

   assign idx_lo   = idx_ff[CAND_BITS-1:0];
   assign ram_addr = MEM_ABITS'({cur_ff, idx_lo});
   assign ram_we   = cmd.store_step && !sts.store_done;

   soa_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MEM_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata ({wkw_ff[idx_ff], wks_ff[idx_ff]}),
      .rdata (ram_rdata)
   );

   logic [CNT_BITS-1:0]  cnt_cur;
   logic                 used_cur, pres_cur;
   logic [WRITER_ID_BITS-1:0] ownw_cur;
   logic signed [31:0]   owns_cur;
   assign cnt_cur  = cnt_ff[cur_ff];
   assign used_cur = used_ff[cur_ff];
   assign pres_cur = pres_ff[cur_ff];
   assign ownw_cur = ownw_ff[cur_ff];
   assign owns_cur = owns_ff[cur_ff];

   // list needed unless a plain fast path covers the op
   logic need;
   always_comb begin
      need = 1'b0;
      unique case (req_ff.op)
         OP_SAMPLE: need = used_cur && pres_cur &&
                           !(ownw_cur == req_ff.writer && owns_cur <= req_ff.strength);
         OP_UNREGISTER, OP_REMOVE_ALL, OP_OWNER_LOST: need = used_cur;
         default: need = 1'b0;
      endcase
   end

   // any used slot above the current one
   logic more;
   always_comb begin
      more = 1'b0;
      for (int i = 0; i < NUM_INSTANCES; i++) begin
         if (SLOT_BITS'(i) > cur_ff && used_ff[i]) more = 1'b1;
      end
   end

   always_comb begin
      sts.load_done  = idx_ff >= WK_BITS'(cnt_cur);
      sts.sort_done  = si_ff >= wkn_ff;
      sts.store_done = idx_ff >= wkn_ff || idx_ff >= WK_BITS'(MAX_CANDIDATES);
      sts.slot_used  = used_cur;
      sts.more_used  = more;
      sts.need_list  = need;
   end

   // find writer in list
   logic                 fnd;
   logic [WK_BITS-1:0]   fidx;
   always_comb begin
      fnd  = 1'b0;
      fidx = '0;
      for (int i = WK_DEPTH - 1; i >= 0; i--) begin
         if (WK_BITS'(i) < wkn_ff && wkw_ff[i] == req_ff.writer) begin
            fnd  = 1'b1;
            fidx = WK_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         pres_ff <= '0;
         for (int i = 0; i < NUM_INSTANCES; i++) begin
            ownw_ff[i] <= NO_WRITER;
            owns_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         req_ff <= '0;
         cur_ff <= '0;
         idx_ff <= '0;
         si_ff  <= '0;
         sj_ff  <= '0;
         wkn_ff <= '0;
         chg_ff <= 1'b0;
         drp_ff <= 1'b0;
         promote_ff <= 1'b0;
         commit_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         pres_ff <= pres_in;
         if (cmd.take_req) begin
            req_ff <= req_in;
            cur_ff <= req_in.inst;
         end
         if (cmd.set_slot) cur_ff <= cmd.scan_slot;
         if (cmd.load_start) begin
            idx_ff <= '0;
            wkn_ff <= '0;
            chg_ff <= 1'b0;
            drp_ff <= 1'b0;
            promote_ff <= 1'b0;
            commit_ff <= 1'b0;
         end
         if (cmd.load_step) begin
            // RAM data is for idx_ff-1 (registered read)
            if (idx_ff != '0) begin
               wkw_ff[idx_ff-1] <= ram_rdata[ENTRY_BITS-1:32];
               wks_ff[idx_ff-1] <= ram_rdata[31:0];
               wkn_ff <= idx_ff;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.process) begin
            si_ff <= WK_BITS'(1);
            sj_ff <= WK_BITS'(1);
            commit_ff <= 1'b1;
            unique case (req_ff.op)
               OP_SAMPLE: begin
                  if (ownw_cur == req_ff.writer) begin
                     wkw_ff[wkn_ff] <= req_ff.writer;
                     wks_ff[wkn_ff] <= req_ff.strength;
                     wkn_ff <= wkn_ff + 1'b1;
                     promote_ff <= 1'b1;
                     chg_ff <= 1'b1;
                  end else if (req_ff.strength > owns_cur) begin
                     wkw_ff[wkn_ff] <= ownw_cur;
                     wks_ff[wkn_ff] <= owns_cur;
                     promote_ff <= 1'b1;
                     chg_ff <= 1'b1;
                     if (fnd) begin
                        wks_ff[fidx] <= req_ff.strength;
                        wkn_ff <= wkn_ff + 1'b1;
                     end else begin
                        wkw_ff[wkn_ff+1] <= req_ff.writer;
                        wks_ff[wkn_ff+1] <= req_ff.strength;
                        wkn_ff <= wkn_ff + 2'd2;
                     end
                  end else if (fnd) begin
                     wks_ff[fidx] <= req_ff.strength;
                  end else begin
                     wkw_ff[wkn_ff] <= req_ff.writer;
                     wks_ff[wkn_ff] <= req_ff.strength;
                     wkn_ff <= wkn_ff + 1'b1;
                  end
               end
               OP_OWNER_LOST: begin
                  promote_ff <= 1'b1;
                  chg_ff <= 1'b1;
               end
               default: begin   // unregister, remove everywhere
                  if (pres_cur && ownw_cur == req_ff.writer) begin
                     promote_ff <= 1'b1;
                     chg_ff <= 1'b1;
                  end else if (fnd) begin
                     for (int i = 0; i < WK_DEPTH - 1; i++) begin
                        if (WK_BITS'(i) >= fidx) begin
                           wkw_ff[i] <= wkw_ff[i+1];
                           wks_ff[i] <= wks_ff[i+1];
                        end
                     end
                     wkn_ff <= wkn_ff - 1'b1;
                  end
               end
            endcase
         end
         if (cmd.sort_step && !sts.sort_done) begin
            if (sj_ff != '0 && wks_ff[sj_ff-1] < wks_ff[sj_ff]) begin
               wkw_ff[sj_ff]   <= wkw_ff[sj_ff-1];
               wks_ff[sj_ff]   <= wks_ff[sj_ff-1];
               wkw_ff[sj_ff-1] <= wkw_ff[sj_ff];
               wks_ff[sj_ff-1] <= wks_ff[sj_ff];
               sj_ff <= sj_ff - 1'b1;
            end else begin
               si_ff <= si_ff + 1'b1;
               sj_ff <= si_ff + 1'b1;
            end
         end
         if (cmd.finish) begin
            idx_ff <= '0;
            if (promote_ff) begin
               if (wkn_ff == '0) begin
                  ownw_ff[cur_ff] <= NO_WRITER;
                  owns_ff[cur_ff] <= '0;
               end else begin
                  ownw_ff[cur_ff] <= wkw_ff[0];
                  owns_ff[cur_ff] <= wks_ff[0];
                  for (int i = 0; i < WK_DEPTH - 1; i++) begin
                     wkw_ff[i] <= wkw_ff[i+1];
                     wks_ff[i] <= wks_ff[i+1];
                  end
                  wkn_ff <= wkn_ff - 1'b1;
               end
            end
         end
         if (cmd.store_step) begin
            if (sts.store_done) begin
               if (wkn_ff > WK_BITS'(MAX_CANDIDATES)) drp_ff <= 1'b1;
               cnt_ff[cur_ff] <= (wkn_ff > WK_BITS'(MAX_CANDIDATES)) ?
                                 CNT_BITS'(MAX_CANDIDATES) : CNT_BITS'(wkn_ff);
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         // fast path ops change owner state at emit time
         if (cmd.emit && !commit_ff && req_ff.op == OP_SAMPLE) begin
            if (!used_cur) cnt_ff[cur_ff] <= '0;
            ownw_ff[cur_ff] <= (used_cur && pres_cur) ? ownw_cur : req_ff.writer;
            owns_ff[cur_ff] <= req_ff.strength;
         end
         if (cmd.emit && req_ff.op == OP_DISPOSE && used_cur) begin
            ownw_ff[cur_ff] <= NO_WRITER;
            owns_ff[cur_ff] <= '0;
            cnt_ff[cur_ff]  <= '0;
         end
      end
   end

   // owner presence/used bits
   always_comb begin
      used_in = used_ff;
      pres_in = pres_ff;
      if (cmd.finish && promote_ff) pres_in[cur_ff] = (wkn_ff != '0);
      if (cmd.emit && !commit_ff && req_ff.op == OP_SAMPLE) begin
         used_in[cur_ff] = 1'b1;
         pres_in[cur_ff] = 1'b1;
      end
      if (cmd.emit && req_ff.op == OP_DISPOSE && used_cur) begin
         used_in[cur_ff] = 1'b0;
         pres_in[cur_ff] = 1'b0;
      end
   end

   // owner fields as they stand once the emit update has taken effect
   logic                      fast_chg;
   logic                      emit_ok;
   logic [WRITER_ID_BITS-1:0] emit_own;
   always_comb begin
      fast_chg = 1'b0;
      emit_ok  = used_cur && pres_cur;
      emit_own = ownw_cur;
      if (req_ff.op == OP_SAMPLE && !commit_ff) begin
         fast_chg = !(used_cur && pres_cur);
         emit_ok  = 1'b1;
         emit_own = (used_cur && pres_cur) ? ownw_cur : req_ff.writer;
      end
      if (req_ff.op == OP_DISPOSE) begin
         fast_chg = used_cur;
         emit_ok  = 1'b0;
      end
      if (!emit_ok) emit_own = NO_WRITER;
   end

   // full result register, so a waiting result needs nothing else held
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.slot          <= cur_ff;
         rsp_ff.owner_id      <= emit_own;
         rsp_ff.owner_valid   <= emit_ok;
         rsp_ff.owner_changed <= (chg_ff && commit_ff) || fast_chg;
         rsp_ff.owner_match   <= emit_ok && emit_own == req_ff.writer &&
                                 req_ff.op <= OP_QUERY;
         rsp_ff.dropped       <= drp_ff && commit_ff && req_ff.op == OP_SAMPLE;
         rsp_ff.last          <= cmd.emit_last;
      end
   end
   assign rsp = rsp_ff;

`ifndef SYNTH
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_cur <= CNT_BITS'(MAX_CANDIDATES)) else $error("candidate count overflow");
   a_list_max: assert property (@(posedge clock) disable iff (reset)
      wkn_ff <= WK_BITS'(WK_DEPTH)) else $error("work list overflow");
   a_no_ram_in_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_step |-> !ram_we) else $error("write during load");
`endif
endmodule
`default_nettype wire

// ----- rtl/soa_ctrl.sv -----
// ----------------------------------------------------------------------------
// soa_ctrl: operation sequencer
// Walks each list operation through load, edit, sort, store and result phases
// (others skip to the result), and loops over used slots for remove-everywhere.
// ----------------------------------------------------------------------------
`default_nettype none
module soa_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire  soa_pkg::req_type req_in,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   input  wire  soa_pkg::sts_type sts,
   output soa_pkg::cmd_type  cmd
);
   import soa_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_PROC  = 4'd3;
   localparam logic [3:0] S_SORT  = 4'd4;
   localparam logic [3:0] S_FIN   = 4'd5;
   localparam logic [3:0] S_STORE = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;
   localparam logic [3:0] S_WAIT  = 4'd8;
   localparam logic [3:0] S_SCAN  = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [SLOT_BITS:0]     scan_ff, scan_in;
   logic                   all_ff, all_in;
   logic                   vld_ff, vld_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      all_in   = all_ff;
      vld_in   = vld_ff && !rsp_tready;
      cmd      = '0;
      cmd.scan_slot = scan_ff[SLOT_BITS-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.take_req = 1'b1;
               all_in = req_in.op == OP_REMOVE_ALL;
               scan_in = '0;
               state_in = (req_in.op == OP_REMOVE_ALL) ? S_SCAN : S_CHECK;
            end
         end
         S_SCAN: begin
            if (scan_ff == (SLOT_BITS+1)'(NUM_INSTANCES)) begin
               state_in = S_IDLE;
            end else begin
               cmd.set_slot = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.load_start = 1'b1;
            if (all_ff && !sts.slot_used) begin
               scan_in = scan_ff + 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = sts.need_list ? S_LOAD : S_EMIT;
            end
         end
         S_LOAD: begin
            cmd.load_step = 1'b1;
            if (sts.load_done) state_in = S_PROC;
         end
         S_PROC: begin
            cmd.process = 1'b1;
            state_in = S_SORT;
         end
         S_SORT: begin
            cmd.sort_step = 1'b1;
            if (sts.sort_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store_step = 1'b1;
            if (sts.store_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!vld_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               cmd.emit_last = !all_ff || !sts.more_used;
               vld_in = 1'b1;
               if (all_ff && sts.more_used) begin
                  scan_in = scan_ff + 1'b1;
                  state_in = S_WAIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_WAIT: begin
            // advance to the next slot of the scan
            state_in = S_SCAN;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= '0;
         all_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         all_ff   <= all_in;
         vld_ff   <= vld_in;
      end
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("accept while busy");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!vld_ff || rsp_tready)) else $error("result overwritten");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= (SLOT_BITS+1)'(NUM_INSTANCES)) else $error("scan overrun");
`endif
endmodule
`default_nettype wire

// ----- rtl/strength_ownership_arbiter_top.sv -----
// ----------------------------------------------------------------------------
// strength_ownership_arbiter_top: exclusive ownership by writer strength
// Top level: controller plus datapath behind stream ports.
// ----------------------------------------------------------------------------
// One operation is handled at a time. An operation that needs no candidate
// list (query, dispose, a first or an owner's own non-weaker sample) goes from
// accept through the check state straight to the result. One that touches the
// list loads its n entries, edits them (at most 10 remain), insertion sorts them
// one swap a cycle, promotes a new owner where needed and stores back at most 8
// entries, one entry a cycle through the candidate memory port. Remove-everywhere
// repeats the list walk for each used slot and steps past each unused slot below
// the last used one. The full result register holds a finished result while the
// next transaction is accepted and worked on.
`default_nettype none
module strength_ownership_arbiter_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,  // op[2:0], instance_req[6:3], writer[14:7], strength[46:15]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,  // slot[3:0], owner_id[11:4], owner_valid, owner_changed,
                                   // is_owner, dropped
   output logic        rsp_tlast
);
   import soa_pkg::*;

   req_type req;
   cmd_type cmd;
   sts_type sts;
   rsp_type rsp;

   assign req.op       = req_tdata[2:0];
   assign req.inst     = req_tdata[6:3];
   assign req.writer   = req_tdata[14:7];
   assign req.strength = req_tdata[46:15];

   soa_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_in(req),
      .rsp_tvalid, .rsp_tready, .sts, .cmd
   );

   soa_datapath u_dp (
      .clock, .reset, .req_in(req), .cmd, .sts, .rsp
   );

   assign rsp_tdata = {rsp.dropped, rsp.owner_match, rsp.owner_changed,
                       rsp.owner_valid, rsp.owner_id, rsp.slot};
   assign rsp_tlast = rsp.last;
endmodule
`default_nettype wire
